// ===== rtl/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types, constants and helpers for the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

    localparam int HISTORY_BITS  = 16;
    localparam int TABLE_ENTRIES = 65536;   // power of two

    localparam int ADDR_W = 16;
    localparam int CTR_W  = 2;
    localparam int CNT_W  = 32;
    localparam int HIST_W = HISTORY_BITS;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int RAW_W  = (HIST_W > ADDR_W) ? HIST_W : ADDR_W;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CTR_W-1:0]  ctr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [HIST_W-1:0] hist_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RAW_W-1:0]  raw_t;

    localparam ctr_t CTR_MIN      = ctr_t'(0);
    localparam ctr_t CTR_MAX      = ctr_t'(3);
    localparam ctr_t TAKEN_THRESH = ctr_t'(2);
    localparam cnt_t COUNT_MAX    = '1;
    localparam idx_t IDX_LAST     = idx_t'(TABLE_ENTRIES - 1);

    // stage 0 to stage 1
    typedef struct packed {
        logic valid;
        idx_t idx;
        logic taken;
    } issue_t;

    // table clearing sequencer
    typedef struct packed {
        logic busy;
        idx_t addr;
    } clear_t;

    // counter write-back
    typedef struct packed {
        logic we;
        idx_t idx;
        ctr_t ctr;
    } wr_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == COUNT_MAX) ? v : v + cnt_t'(1);
    endfunction

    function automatic ctr_t ctr_step(input ctr_t c, input logic taken);
        ctr_t r;
        if (taken)
        begin
            r = (c == CTR_MAX) ? c : c + ctr_t'(1);
        end
        else
        begin
            r = (c == CTR_MIN) ? c : c - ctr_t'(1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/gbp_if.sv =====
// ----------------------------------------------------------------------------
// gbp interfaces
// Valid/ready channels: resolved branches in, predictions out, config write.
// ----------------------------------------------------------------------------
interface branch_if;
    import gbp_pkg::*;

    logic  valid;
    logic  ready;
    addr_t branch_address;
    logic  outcome_taken;

    modport source (output valid, branch_address, outcome_taken, input ready);
    modport sink   (input valid, branch_address, outcome_taken, output ready);
endinterface

interface result_if;
    import gbp_pkg::*;

    logic valid;
    logic ready;
    logic predicted_taken;
    logic prediction_correct;
    cnt_t branches_seen;
    cnt_t branches_taken;
    cnt_t predictions_right;

    modport source (output valid, predicted_taken, prediction_correct, branches_seen,
                    branches_taken, predictions_right, input ready);
    modport sink   (input valid, predicted_taken, prediction_correct, branches_seen,
                    branches_taken, predictions_right, output ready);
endinterface

interface cfg_if;
    logic valid;
    logic ready;
    logic use_history;

    modport source (output valid, use_history, input ready);
    modport sink   (input valid, use_history, output ready);
endinterface

// ===== rtl/gshare_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// gshare predictor with 2-bit saturating counters and saturating statistics.
// ----------------------------------------------------------------------------
// Channels: branch (sink) takes one resolved branch per word: index bits of
// the address and the outcome. result (source) returns one word per branch:
// the prediction made before the update, whether it was right, and the
// running branch, taken and correct counts (all stop at all-ones).
// cfg (sink) writes use_history and is always ready; use_history must only be
// written while no branch is in flight, which the block does not enforce.
// An accepted branch waits in stage 1 while its counter is read, then its
// result word is registered. Throughput: one branch per cycle when not
// stalled, set by the single counter table RAM (one read and one write
// port); back-to-back hits on one entry are forwarded from the last write.
// Reset: history and counts clear, use_history is 1, and the counter table
// is cleared one entry per cycle, all 65536 entries, while branch.ready
// is low. cfg writes are taken throughout.
// Stall: while a result word is valid and result.ready is low, the word
// holds, the one branch already read waits, and branch.ready drops.
// ----------------------------------------------------------------------------
module gshare_branch_predictor (
    input  logic     clk,
    input  logic     rst_n,
    branch_if.sink   branch,
    result_if.source result,
    cfg_if.sink      cfg
);
    import gbp_pkg::*;

    logic   adv;
    logic   rd_en;
    idx_t   rd_idx;
    ctr_t   rd_ctr;
    issue_t issue;
    clear_t clr;
    wr_t    wr;
    logic   ram_we;
    idx_t   ram_waddr;
    ctr_t   ram_wdata;

    gbp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .branch (branch),
        .cfg    (cfg),
        .adv    (adv),
        .rd_en  (rd_en),
        .rd_idx (rd_idx),
        .issue  (issue),
        .clr    (clr)
    );

    assign ram_we    = clr.busy || wr.we;
    assign ram_waddr = clr.busy ? clr.addr : wr.idx;
    assign ram_wdata = clr.busy ? CTR_MIN : wr.ctr;

    gbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_idx),
        .rdata (rd_ctr)
    );

    gbp_update u_update (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .rd_ctr (rd_ctr),
        .result (result),
        .adv    (adv),
        .wr     (wr)
    );

endmodule

// ===== rtl/gbp_ram.sv =====
// ----------------------------------------------------------------------------
// gbp_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/gbp_front.sv =====
// ----------------------------------------------------------------------------
// gbp_front
// Input acceptance, global history, table index and post-reset table clear.
// ----------------------------------------------------------------------------
module gbp_front (
    input  logic            clk,
    input  logic            rst_n,
    branch_if.sink          branch,
    cfg_if.sink             cfg,
    input  logic            adv,
    output logic            rd_en,
    output gbp_pkg::idx_t   rd_idx,
    output gbp_pkg::issue_t issue,
    output gbp_pkg::clear_t clr
);
    import gbp_pkg::*;

    logic   use_hist_reg, use_hist_next;
    hist_t  hist_reg, hist_next;
    logic   s1_valid_reg, s1_valid_next;
    idx_t   s1_idx_reg;
    logic   s1_taken_reg;
    logic   clr_busy_reg, clr_busy_next;
    idx_t   clr_addr_reg, clr_addr_next;
    logic   accept;
    raw_t   raw;
    idx_t   idx;

    assign cfg.ready    = 1'b1;
    assign branch.ready = !clr_busy_reg && adv;
    assign accept       = branch.valid && branch.ready;

    assign raw = raw_t'(branch.branch_address) ^ (use_hist_reg ? raw_t'(hist_reg) : '0);
    assign idx = idx_t'(raw);

    assign rd_en  = accept;
    assign rd_idx = idx;

    always_comb
    begin
        use_hist_next = cfg.valid ? cfg.use_history : use_hist_reg;
        hist_next     = accept ? hist_t'({hist_reg, branch.outcome_taken}) : hist_reg;
        s1_valid_next = adv ? accept : s1_valid_reg;
        clr_busy_next = clr_busy_reg && (clr_addr_reg != IDX_LAST);
        clr_addr_next = clr_busy_reg ? clr_addr_reg + idx_t'(1) : clr_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_hist_reg <= 1'b1;
            hist_reg     <= '0;
            s1_valid_reg <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            use_hist_reg <= use_hist_next;
            hist_reg     <= hist_next;
            s1_valid_reg <= s1_valid_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= idx;
            s1_taken_reg <= branch.outcome_taken;
        end
    end

    assign issue.valid = s1_valid_reg;
    assign issue.idx   = s1_idx_reg;
    assign issue.taken = s1_taken_reg;
    assign clr.busy    = clr_busy_reg;
    assign clr.addr    = clr_addr_reg;

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !branch.ready)
        else $error("branch accepted during table clear");

    a_clear_runs_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("table clear restarted");

    a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s1_valid_reg)
        else $error("branch in flight during table clear");

endmodule

// ===== rtl/gbp_update.sv =====
// ----------------------------------------------------------------------------
// gbp_update
// Prediction, counter update with write forwarding, statistics, output word.
// ----------------------------------------------------------------------------
module gbp_update (
    input  logic            clk,
    input  logic            rst_n,
    input  gbp_pkg::issue_t issue,
    input  gbp_pkg::ctr_t   rd_ctr,
    result_if.source        result,
    output logic            adv,
    output gbp_pkg::wr_t    wr
);
    import gbp_pkg::*;

    logic   out_valid_reg, out_valid_next;
    logic   pred_reg;
    logic   right_reg;
    cnt_t   seen_reg, seen_next;
    cnt_t   taken_reg, taken_next;
    cnt_t   correct_reg, correct_next;
    logic   fwd_valid_reg, fwd_valid_next;
    idx_t   fwd_idx_reg;
    ctr_t   fwd_ctr_reg;
    logic   go;
    ctr_t   ctr_cur;
    ctr_t   ctr_new;
    logic   pred;
    logic   right;

    assign adv = !out_valid_reg || result.ready;
    assign go  = issue.valid && adv;

    // write in the same edge as the read returns old data
    assign ctr_cur = (fwd_valid_reg && (fwd_idx_reg == issue.idx)) ? fwd_ctr_reg : rd_ctr;
    assign pred    = (ctr_cur >= TAKEN_THRESH);
    assign right   = (pred == issue.taken);
    assign ctr_new = ctr_step(ctr_cur, issue.taken);

    assign wr.we  = go;
    assign wr.idx = issue.idx;
    assign wr.ctr = ctr_new;

    always_comb
    begin
        out_valid_next = go ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
        fwd_valid_next = fwd_valid_reg || go;
        seen_next      = seen_reg;
        taken_next     = taken_reg;
        correct_next   = correct_reg;
        if (go)
        begin
            seen_next = sat_inc(seen_reg);
            if (issue.taken)
            begin
                taken_next = sat_inc(taken_reg);
            end
            if (right)
            begin
                correct_next = sat_inc(correct_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            seen_reg      <= '0;
            taken_reg     <= '0;
            correct_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            seen_reg      <= seen_next;
            taken_reg     <= taken_next;
            correct_reg   <= correct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pred_reg    <= pred;
            right_reg   <= right;
            fwd_idx_reg <= issue.idx;
            fwd_ctr_reg <= ctr_new;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.predicted_taken    = pred_reg;
    assign result.prediction_correct = right_reg;
    assign result.branches_seen      = seen_reg;
    assign result.branches_taken     = taken_reg;
    assign result.predictions_right  = correct_reg;

    a_taken_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= seen_reg)
        else $error("taken count exceeds branch count");

    a_correct_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        correct_reg <= seen_reg)
        else $error("correct count exceeds branch count");

    a_stall_holds_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(seen_reg))
        else $error("statistics moved while output word stalled");

endmodule

// ===== tb/tb_gshare_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tb_gshare_branch_predictor
// Self-checking bench for the gshare predictor. A short table of branches
// (a few with hand-worked results) is followed by random runs of branches
// per history setting. Branch traffic is biased so that counters train and
// saturate and entries are hit back to back. Each run has its own idle and
// stall mix. Every result word is checked against its hand-worked or in-bench prediction.
// ----------------------------------------------------------------------------
module tb_gshare_branch_predictor;
    timeunit 1ns;
    timeprecision 1ps;

    import gbp_pkg::*;

    typedef struct packed {
        logic pred;
        logic right;
        cnt_t seen;
        cnt_t tkn;
        cnt_t ok;
    } res_word_t;

    typedef struct packed {
        logic      wr_cfg;
        logic      cfg_val;
        addr_t     addr;
        logic      taken;
        logic      typed;
        res_word_t exp;
    } row_t;

    typedef struct {
        int   items;
        int   tx_pct;
        int   rx_pct;
        logic hist;
        logic squeeze;
    } phase_t;

    localparam res_word_t NO_EXP   = '0;
    localparam int        DIR_N    = 20;
    localparam int        PHASE_N  = 5;
    localparam int        HOLD_LEN = 400;
    localparam int        WD_LIMIT = 210000;    // covers the post-reset table clear

    // directed branches; hand-worked results only for the first few after reset
    row_t dir_rows [DIR_N] = '{
        '{1'b0, 1'b0, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
        '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b1, '{1'b0, 1'b1, 32'd2, 32'd1, 32'd1}},
        '{1'b0, 1'b0, 16'h0001, 1'b0, 1'b1, '{1'b0, 1'b1, 32'd3, 32'd1, 32'd2}},
        '{1'b0, 1'b0, 16'hAAAA, 1'b1, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h5555, 1'b0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h8000, 1'b1, 1'b0, NO_EXP},
        '{1'b1, 1'b0, 16'h1234, 1'b1, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h1234, 1'b1, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h1234, 1'b1, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h1234, 1'b1, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h1234, 1'b0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h1234, 1'b0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h1234, 1'b0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h1234, 1'b0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, NO_EXP},
        '{1'b1, 1'b1, 16'h7FFF, 1'b1, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h7FFF, 1'b1, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'hFFFF, 1'b1, 1'b0, NO_EXP},
        '{1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, NO_EXP}
    };

    phase_t phases [PHASE_N] = '{
        '{250, 0,  0,  1'b1, 1'b0},
        '{220, 74, 0,  1'b0, 1'b0},
        '{220, 0,  74, 1'b1, 1'b0},
        '{220, 25, 25, 1'b0, 1'b0},
        '{220, 0,  0,  1'b1, 1'b1}
    };

    logic clk;
    logic rst_n;

    branch_if branch();
    result_if result();
    cfg_if    cfg();

    gshare_branch_predictor u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .branch (branch),
        .result (result),
        .cfg    (cfg)
    );

    // bench copy of the predictor state
    ctr_t  pht [TABLE_ENTRIES];
    hist_t ghr;
    cnt_t  n_seen;
    cnt_t  n_taken;
    cnt_t  n_right;
    logic  hist_on;

    res_word_t pending_predictions [$];

    int mismatches;
    int n_sent;
    int n_checked;
    int n_cfg;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic res_word_t predict_and_train(input addr_t a, input logic t);
        raw_t      mix;
        idx_t      slot;
        ctr_t      c;
        res_word_t w;
        mix  = hist_on ? (raw_t'(a) ^ raw_t'(ghr)) : raw_t'(a);
        slot = idx_t'(mix % TABLE_ENTRIES);
        c    = pht[slot];
        w.pred  = (c >= TAKEN_THRESH);
        w.right = (w.pred == t);
        if (n_seen != COUNT_MAX)
        begin
            n_seen = n_seen + 1'b1;
        end
        if (t && n_taken != COUNT_MAX)
        begin
            n_taken = n_taken + 1'b1;
        end
        if (w.right && n_right != COUNT_MAX)
        begin
            n_right = n_right + 1'b1;
        end
        if (t)
        begin
            if (c != CTR_MAX)
            begin
                c = c + 1'b1;
            end
        end
        else
        begin
            if (c != CTR_MIN)
            begin
                c = c - 1'b1;
            end
        end
        pht[slot] = c;
        ghr       = {ghr[HIST_W-2:0], t};
        w.seen    = n_seen;
        w.tkn     = n_taken;
        w.ok      = n_right;
        return w;
    endfunction

    // leaves valid high on return; the caller lowers it for a gap
    task automatic offer_branch(input addr_t a, input logic t, input logic typed,
                                input res_word_t typed_exp);
        res_word_t w;
        branch.valid          <= 1'b1;
        branch.branch_address <= a;
        branch.outcome_taken  <= t;
        @(posedge clk);
        while (!branch.ready)
        begin
            @(posedge clk);
        end
        w = predict_and_train(a, t);
        pending_predictions.push_back(typed ? typed_exp : w);
        n_sent++;
    endtask

    task automatic wait_idle();
        branch.valid <= 1'b0;
        @(posedge clk);
        while (pending_predictions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic v);
        cfg.use_history <= v;
        cfg.valid       <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
        hist_on = v;
        n_cfg++;
    endtask

    task automatic cmp_field(input string what, input cnt_t want, input cnt_t got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // result sink: checks each word and drives ready
    initial
    begin
        res_word_t w;
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                if (pending_predictions.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, expected none got seen=%0d",
                             $time, result.branches_seen);
                end
                else
                begin
                    w = pending_predictions.pop_front();
                    cmp_field("predicted_taken", cnt_t'(w.pred), cnt_t'(result.predicted_taken));
                    cmp_field("prediction_correct", cnt_t'(w.right),
                              cnt_t'(result.prediction_correct));
                    cmp_field("branches_seen", w.seen, result.branches_seen);
                    cmp_field("branches_taken", w.tkn, result.branches_taken);
                    cmp_field("predictions_right", w.ok, result.predictions_right);
                    n_checked++;
                end
            end
            if (hold_cycles > 0)
            begin
                result.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                result.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WD_LIMIT)
        begin
            @(posedge clk);
            if ((branch.valid && branch.ready) || (result.valid && result.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no word moved for %0d cycles", $time, WD_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int    i;
        int    p;
        int    k;
        int    pick;
        int    run_left;
        int    run_bias;
        addr_t run_addr;
        addr_t hot_addr [8];
        logic  t;

        branch.valid          <= 1'b0;
        branch.branch_address <= '0;
        branch.outcome_taken  <= 1'b0;
        result.ready          <= 1'b0;
        cfg.valid             <= 1'b0;
        cfg.use_history       <= 1'b0;
        rst_n                 <= 1'b0;

        foreach (pht[k])
        begin
            pht[k] = CTR_MIN;
        end
        ghr          = '0;
        n_seen       = '0;
        n_taken      = '0;
        n_right      = '0;
        hist_on      = 1'b1;
        mismatches   = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_cfg        = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_cycles  = 0;
        run_left     = 0;
        run_bias     = 50;
        run_addr     = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_N; i++)
        begin
            if (dir_rows[i].wr_cfg)
            begin
                wait_idle();
                write_cfg(dir_rows[i].cfg_val);
            end
            offer_branch(dir_rows[i].addr, dir_rows[i].taken, dir_rows[i].typed,
                         dir_rows[i].exp);
        end

        for (p = 0; p < PHASE_N; p++)
        begin
            wait_idle();
            write_cfg(phases[p].hist);
            tx_idle_pct  = phases[p].tx_pct;
            rx_stall_pct = phases[p].rx_pct;
            for (k = 0; k < 8; k++)
            begin
                hot_addr[k] = addr_t'($urandom);
            end
            // full-pipe squeeze: sink holds off while branches keep coming
            if (phases[p].squeeze)
            begin
                hold_cycles = HOLD_LEN;
            end
            for (i = 0; i < phases[p].items; i++)
            begin
                if (run_left == 0)
                begin
                    pick = $urandom_range(99);
                    if (pick < 60)
                    begin
                        run_addr = hot_addr[$urandom_range(7)];
                        run_left = $urandom_range(12, 1);
                    end
                    else if (pick < 85)
                    begin
                        run_addr = addr_t'($urandom);
                        run_left = 1;
                    end
                    else
                    begin
                        run_addr = pick[0] ? '1 : '0;
                        run_left = $urandom_range(4, 1);
                    end
                    case ($urandom_range(3))
                        0:       run_bias = 95;
                        1:       run_bias = 5;
                        2:       run_bias = 50;
                        default: run_bias = 80;
                    endcase
                end
                run_left--;
                t = ($urandom_range(99) < run_bias);
                offer_branch(run_addr, t, 1'b0, NO_EXP);
                if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
                begin
                    branch.valid <= 1'b0;
                    do
                        @(posedge clk);
                    while ($urandom_range(99) < tx_idle_pct);
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        mismatches += pending_predictions.size();

        $display("Sent %0d branches, checked %0d result words, %0d use_history writes.",
                 n_sent, n_checked, n_cfg);
        $display("Runs with history on and off, counter training, idle gaps and stalls.");
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gbp_pkg.sv
rtl/gbp_if.sv
rtl/gbp_ram.sv
rtl/gbp_front.sv
rtl/gbp_update.sv
rtl/gshare_branch_predictor.sv
tb/tb_gshare_branch_predictor.sv
